FILE: rtl/core/fresnel_schlick_reflectance_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Fresnel reflectance pipeline
// Short forms for the concurrent checks used in the RTL. They sample on clk
// and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRESNEL_SCHLICK_REFLECTANCE_TOP_MACROS_SVH
`define FRESNEL_SCHLICK_REFLECTANCE_TOP_MACROS_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define FSR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The condition must never be seen at a clock edge.
`define FSR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/core/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared widths and the per-beat flag group of the Fresnel reflectance
// pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsr_pkg;

  // Fixed widths of the interface fields.
  localparam int IN_W   = 16;
  localparam int SUM_W  = 17;
  localparam int PROD_W = 32;
  localparam int REFL_W = 15;

  // Per-beat decisions that travel with the data through every cell.
  typedef struct packed {
    logic tir;       // total internal reflection
    logic refr;      // n1 > n2, refracted cosine replaces the dot product
    logic lhs_zero;  // n1^2 (1 - cos^2) is zero
    logic s_zero;    // n1 + n2 is zero
  } fsr_flags_t;

endpackage

FILE: rtl/core/fsr_front.sv
// ----------------------------------------------------------------------------
// fsr_front
// Dot product, clamp, 1 - cos^2, the n1^2 (1 - cos^2) term and the total
// internal reflection test, five registered stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_front #(
  parameter int FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fsr_pkg::IN_W-1:0]   in_eye_x,
  input  logic signed [fsr_pkg::IN_W-1:0]   in_eye_y,
  input  logic signed [fsr_pkg::IN_W-1:0]   in_eye_z,
  input  logic signed [fsr_pkg::IN_W-1:0]   in_normal_x,
  input  logic signed [fsr_pkg::IN_W-1:0]   in_normal_y,
  input  logic signed [fsr_pkg::IN_W-1:0]   in_normal_z,
  input  logic        [fsr_pkg::IN_W-1:0]   in_n1_index,
  input  logic        [fsr_pkg::IN_W-1:0]   in_n2_index,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [FRAC_BITS+1:0]       cos_o,
  output logic        [FRAC_BITS+32:0]      lhs_o,
  output logic        [fsr_pkg::PROD_W-1:0] n2sq_o,
  output logic        [fsr_pkg::IN_W-1:0]   d_o,
  output logic        [fsr_pkg::SUM_W-1:0]  s_o,
  output fsr_pkg::fsr_flags_t               flags_o
);

  localparam int CW = FRAC_BITS + 2;
  localparam int OW = FRAC_BITS + 1;
  localparam int LW = FRAC_BITS + 33;
  localparam int DW = 34;
  localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< FRAC_BITS;
  localparam logic        [OW-1:0] ONE_U = OW'(1) << FRAC_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  logic signed [fsr_pkg::PROD_W-1:0] p0_r, p1_r, p2_r;
  logic [fsr_pkg::PROD_W-1:0] n1sq1_r, n1sq2_r, n1sq3_r;
  logic [fsr_pkg::PROD_W-1:0] n2sq1_r, n2sq2_r, n2sq3_r, n2sq4_r, n2sq5_r;
  logic [fsr_pkg::IN_W-1:0]   d1_r, d2_r, d3_r, d4_r, d5_r;
  logic [fsr_pkg::SUM_W-1:0]  s1_r, s2_r, s3_r, s4_r, s5_r;
  fsr_pkg::fsr_flags_t        f1_r, f2_r, f3_r, f4_r, f5_r, f1_nxt, f5_nxt;
  logic signed [CW-1:0]       cos2_r, cos3_r, cos4_r, cos5_r, cos2_nxt;
  logic [OW-1:0]              omc3_r, omc3_nxt;
  logic [LW-1:0]              lhs4_r, lhs5_r;

  logic signed [DW-1:0]   dot, dsh;
  logic signed [2*CW-1:0] csq;
  logic [OW-1:0]          c2;

  // Ripple ready: a stage moves when it is empty or its neighbor moves.
  assign adv5     = !v5_r || dn_ready;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign dn_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // Stage 1: the three component products and the squared indices.
  always_comb begin
    f1_nxt          = '0;
    f1_nxt.refr     = in_n1_index > in_n2_index;
    f1_nxt.s_zero   = (in_n1_index == '0) && (in_n2_index == '0);
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      p0_r    <= in_eye_x * in_normal_x;
      p1_r    <= in_eye_y * in_normal_y;
      p2_r    <= in_eye_z * in_normal_z;
      n1sq1_r <= in_n1_index * in_n1_index;
      n2sq1_r <= in_n2_index * in_n2_index;
      d1_r    <= (in_n1_index > in_n2_index) ? in_n1_index - in_n2_index
                                             : in_n2_index - in_n1_index;
      s1_r    <= fsr_pkg::SUM_W'(in_n1_index) + fsr_pkg::SUM_W'(in_n2_index);
      f1_r    <= f1_nxt;
    end
  end

  // Stage 2: sum, floor rescale and clamp to [-1, 1].
  assign dot = DW'(p0_r) + DW'(p1_r) + DW'(p2_r);
  assign dsh = dot >>> FRAC_BITS;

  always_comb begin
    if (dsh > ONE_D) begin
      cos2_nxt = CW'(ONE_D);
    end else if (dsh < -ONE_D) begin
      cos2_nxt = CW'(-ONE_D);
    end else begin
      cos2_nxt = CW'(dsh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      cos2_r  <= cos2_nxt;
      n1sq2_r <= n1sq1_r;
      n2sq2_r <= n2sq1_r;
      d2_r    <= d1_r;
      s2_r    <= s1_r;
      f2_r    <= f1_r;
    end
  end

  // Stage 3: 1 - cos^2.
  assign csq      = cos2_r * cos2_r;
  assign c2       = OW'(csq >>> FRAC_BITS);
  assign omc3_nxt = ONE_U - c2;

  always_ff @(posedge clk) begin
    if (adv3) begin
      omc3_r  <= omc3_nxt;
      cos3_r  <= cos2_r;
      n1sq3_r <= n1sq2_r;
      n2sq3_r <= n2sq2_r;
      d3_r    <= d2_r;
      s3_r    <= s2_r;
      f3_r    <= f2_r;
    end
  end

  // Stage 4: n1^2 (1 - cos^2).
  always_ff @(posedge clk) begin
    if (adv4) begin
      lhs4_r  <= LW'(n1sq3_r) * LW'(omc3_r);
      cos4_r  <= cos3_r;
      n2sq4_r <= n2sq3_r;
      d4_r    <= d3_r;
      s4_r    <= s3_r;
      f4_r    <= f3_r;
    end
  end

  // Stage 5: exact total reflection test against n2^2 * 1.
  always_comb begin
    f5_nxt          = f4_r;
    f5_nxt.tir      = f4_r.refr && (lhs4_r > (LW'(n2sq4_r) << FRAC_BITS));
    f5_nxt.lhs_zero = (lhs4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      lhs5_r  <= lhs4_r;
      cos5_r  <= cos4_r;
      n2sq5_r <= n2sq4_r;
      d5_r    <= d4_r;
      s5_r    <= s4_r;
      f5_r    <= f5_nxt;
    end
  end

  assign cos_o   = cos5_r;
  assign lhs_o   = lhs5_r;
  assign n2sq_o  = n2sq5_r;
  assign d_o     = d5_r;
  assign s_o     = s5_r;
  assign flags_o = f5_r;

endmodule

FILE: rtl/core/fsr_div_cell.sv
// ----------------------------------------------------------------------------
// fsr_div_cell
// One restoring step of two dividers at once: sin2_t = lhs / n2^2 and
// q = (d << F) / (n1 + n2). Each cell settles one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_div_cell #(
  parameter int FRAC_BITS = 14,
  parameter int STEP      = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [FRAC_BITS+1:0]       cos_i,
  input  fsr_pkg::fsr_flags_t               flags_i,
  input  logic        [FRAC_BITS+32:0]      lrem_i,
  input  logic        [fsr_pkg::PROD_W-1:0] n2sq_i,
  input  logic        [FRAC_BITS:0]         sq_i,
  input  logic        [FRAC_BITS+16:0]      qrem_i,
  input  logic        [fsr_pkg::SUM_W-1:0]  s_i,
  input  logic        [FRAC_BITS:0]         qq_i,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [FRAC_BITS+1:0]       cos_o,
  output fsr_pkg::fsr_flags_t               flags_o,
  output logic        [FRAC_BITS+32:0]      lrem_o,
  output logic        [fsr_pkg::PROD_W-1:0] n2sq_o,
  output logic        [FRAC_BITS:0]         sq_o,
  output logic        [FRAC_BITS+16:0]      qrem_o,
  output logic        [fsr_pkg::SUM_W-1:0]  s_o,
  output logic        [FRAC_BITS:0]         qq_o
);

  localparam int LW = FRAC_BITS + 33;
  localparam int QW = FRAC_BITS + 17;
  localparam int OW = FRAC_BITS + 1;
  localparam logic [OW-1:0] BIT = OW'(1) << STEP;

  logic v_r;
  logic adv;
  logic [LW-1:0] ldiv;
  logic [QW-1:0] qdiv;
  logic          lfit, qfit;

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = v_r;

  // Shifted divisors and the trial compares.
  assign ldiv = LW'(n2sq_i) << STEP;
  assign qdiv = QW'(s_i) << STEP;
  assign lfit = lrem_i >= ldiv;
  assign qfit = qrem_i >= qdiv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lrem_o  <= lfit ? lrem_i - ldiv : lrem_i;
      sq_o    <= lfit ? (sq_i | BIT) : sq_i;
      qrem_o  <= qfit ? qrem_i - qdiv : qrem_i;
      qq_o    <= qfit ? (qq_i | BIT) : qq_i;
      n2sq_o  <= n2sq_i;
      s_o     <= s_i;
      cos_o   <= cos_i;
      flags_o <= flags_i;
    end
  end

endmodule

FILE: rtl/core/fsr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// fsr_sqrt_cell
// One step of the digit-by-digit integer square root that turns 1 - sin2_t
// into the refracted cosine. Each cell settles one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsr_sqrt_cell #(
  parameter int FRAC_BITS = 14,
  parameter int STEP      = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [FRAC_BITS+1:0] cos_i,
  input  fsr_pkg::fsr_flags_t         flags_i,
  input  logic        [2*FRAC_BITS+1:0] rem_i,
  input  logic        [FRAC_BITS:0]   root_i,
  input  logic        [FRAC_BITS:0]   q_i,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [FRAC_BITS+1:0] cos_o,
  output fsr_pkg::fsr_flags_t         flags_o,
  output logic        [2*FRAC_BITS+1:0] rem_o,
  output logic        [FRAC_BITS:0]   root_o,
  output logic        [FRAC_BITS:0]   q_o
);

  localparam int XW = 2 * FRAC_BITS + 2;
  localparam int OW = FRAC_BITS + 1;
  localparam logic [OW-1:0] BIT = OW'(1) << STEP;

  logic v_r;
  logic adv;
  logic [XW-1:0] trial;
  logic          fit;

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = v_r;

  // Remainder test: (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k).
  assign trial = (XW'(root_i) << (STEP + 1)) + (XW'(1) << (2 * STEP));
  assign fit   = rem_i >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_o   <= fit ? rem_i - trial : rem_i;
      root_o  <= fit ? (root_i | BIT) : root_i;
      q_o     <= q_i;
      cos_o   <= cos_i;
      flags_o <= flags_i;
    end
  end

endmodule

FILE: rtl/core/fsr_back.sv
// ----------------------------------------------------------------------------
// fsr_back
// Schlick polynomial: r0 = q^2, (1 - cos)^5 by repeated squaring, blend and
// saturation, six registered stages ending in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fresnel_schlick_reflectance_top_macros.svh"

module fsr_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [FRAC_BITS+1:0]      cos_i,
  input  logic        [FRAC_BITS:0]        root_i,
  input  logic        [FRAC_BITS:0]        q_i,
  input  fsr_pkg::fsr_flags_t              flags_i,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fsr_pkg::REFL_W-1:0]       out_reflectance,
  output logic                             out_total_reflection
);

  localparam int CW = FRAC_BITS + 2;
  localparam int OW = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 2;
  localparam int PW = 2 * OW;
  localparam logic [OW-1:0] ONE_U = OW'(1) << FRAC_BITS;
  localparam logic [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  logic signed [CW-1:0] cosf;
  logic [PW-1:0] qprod, bprod2, bprod4, bprod5, tprod;
  logic [RW-1:0] sum, refl_nxt;

  logic [OW-1:0] b1_r, b2_r, b3_r;
  logic [OW-1:0] r01_r, r02_r, r03_r, r04_r, r05_r;
  logic [OW-1:0] omr2_r, omr3_r, omr4_r;
  logic [OW-1:0] pb2_r, pb4_r, pb5_r, t5_r;
  logic sat1_r, sat2_r, sat3_r, sat4_r, sat5_r;
  logic tir1_r, tir2_r, tir3_r, tir4_r, tir5_r, tir6_r;
  logic [RW-1:0] refl6_r;

  assign adv6      = !v6_r || out_ready;
  assign adv5      = !v5_r || adv6;
  assign adv4      = !v4_r || adv5;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign up_ready  = adv1;
  assign out_valid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) v6_r <= v5_r;
    end
  end

  // Stage 1: pick the cosine in use, form 1 - cos and r0.
  assign cosf  = (flags_i.refr && !flags_i.tir) ? $signed(CW'(root_i)) : cos_i;
  assign qprod = PW'(q_i) * PW'(q_i);

  always_ff @(posedge clk) begin
    if (adv1) begin
      sat1_r <= flags_i.tir || (cosf <= 0);
      tir1_r <= flags_i.tir;
      b1_r   <= ONE_U - OW'(cosf);
      r01_r  <= OW'(qprod >> FRAC_BITS);
    end
  end

  // Stage 2: (1 - cos)^2 and 1 - r0.
  assign bprod2 = PW'(b1_r) * PW'(b1_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      pb2_r  <= OW'(bprod2 >> FRAC_BITS);
      omr2_r <= ONE_U - r01_r;
      b2_r   <= b1_r;
      r02_r  <= r01_r;
      sat2_r <= sat1_r;
      tir2_r <= tir1_r;
    end
  end

  // Stage 3: fourth power.
  assign bprod4 = PW'(pb2_r) * PW'(pb2_r);

  always_ff @(posedge clk) begin
    if (adv3) begin
      pb4_r  <= OW'(bprod4 >> FRAC_BITS);
      omr3_r <= omr2_r;
      b3_r   <= b2_r;
      r03_r  <= r02_r;
      sat3_r <= sat2_r;
      tir3_r <= tir2_r;
    end
  end

  // Stage 4: fifth power.
  assign bprod5 = PW'(pb4_r) * PW'(b3_r);

  always_ff @(posedge clk) begin
    if (adv4) begin
      pb5_r  <= OW'(bprod5 >> FRAC_BITS);
      omr4_r <= omr3_r;
      r04_r  <= r03_r;
      sat4_r <= sat3_r;
      tir4_r <= tir3_r;
    end
  end

  // Stage 5: (1 - r0) (1 - cos)^5.
  assign tprod = PW'(omr4_r) * PW'(pb5_r);

  always_ff @(posedge clk) begin
    if (adv5) begin
      t5_r   <= OW'(tprod >> FRAC_BITS);
      r05_r  <= r04_r;
      sat5_r <= sat4_r;
      tir5_r <= tir4_r;
    end
  end

  // Stage 6: blend and saturate into the output register.
  assign sum = RW'(r05_r) + RW'(t5_r);

  always_comb begin
    if (sat5_r || (sum > ONE_R)) begin
      refl_nxt = ONE_R;
    end else begin
      refl_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      refl6_r <= refl_nxt;
      tir6_r  <= tir5_r;
    end
  end

  assign out_reflectance      = fsr_pkg::REFL_W'(refl6_r);
  assign out_total_reflection = tir6_r;

  `FSR_ASSERT_IMPLY(a_refl_in_range, out_valid, refl6_r <= ONE_R)
  `FSR_ASSERT_IMPLY(a_tir_gives_one, out_valid && tir6_r, refl6_r == ONE_R)
  `FSR_ASSERT_IMPLY(a_sat_gives_one, v5_r && sat5_r, refl_nxt == ONE_R)

endmodule

FILE: rtl/core/fresnel_schlick_reflectance_top.sv
// ----------------------------------------------------------------------------
// fresnel_schlick_reflectance_top
// Schlick Fresnel reflectance with total internal reflection test, one hit
// per beat through a chain of pipeline cells.
// ----------------------------------------------------------------------------
// The block takes one hit per clock while the sink takes results, and
// returns one reflectance beat per hit, in order. A hit passes through five
// front stages, FRAC_BITS + 1 divider cells that settle one quotient bit
// each for sin2_t and q, FRAC_BITS + 1 square root cells that settle one
// root bit each, and six polynomial stages ending in the output register.
// Every stage holds its beat under back-pressure and empty stages close up,
// so while any stage is empty a new hit is taken even as results wait.
`timescale 1ns / 1ps

`include "fresnel_schlick_reflectance_top_macros.svh"

module fresnel_schlick_reflectance_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [fsr_pkg::IN_W-1:0] in_eye_x,
  input  logic signed [fsr_pkg::IN_W-1:0] in_eye_y,
  input  logic signed [fsr_pkg::IN_W-1:0] in_eye_z,
  input  logic signed [fsr_pkg::IN_W-1:0] in_normal_x,
  input  logic signed [fsr_pkg::IN_W-1:0] in_normal_y,
  input  logic signed [fsr_pkg::IN_W-1:0] in_normal_z,
  input  logic        [fsr_pkg::IN_W-1:0] in_n1_index,
  input  logic        [fsr_pkg::IN_W-1:0] in_n2_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fsr_pkg::REFL_W-1:0]      out_reflectance,
  output logic                            out_total_reflection
);

  localparam int CW    = FRAC_BITS + 2;
  localparam int OW    = FRAC_BITS + 1;
  localparam int LW    = FRAC_BITS + 33;
  localparam int QW    = FRAC_BITS + 17;
  localparam int XW    = 2 * FRAC_BITS + 2;
  localparam int NCELL = FRAC_BITS + 1;
  localparam logic [OW-1:0] ONE_U = OW'(1) << FRAC_BITS;

  // Divider chain links.
  logic                        dv_w    [0:NCELL];
  logic                        dr_w    [0:NCELL];
  logic signed [CW-1:0]        dcos_w  [0:NCELL];
  fsr_pkg::fsr_flags_t         dflag_w [0:NCELL];
  logic [LW-1:0]               lrem_w  [0:NCELL];
  logic [fsr_pkg::PROD_W-1:0]  n2sq_w  [0:NCELL];
  logic [OW-1:0]               sq_w    [0:NCELL];
  logic [QW-1:0]               qrem_w  [0:NCELL];
  logic [fsr_pkg::SUM_W-1:0]   s_w     [0:NCELL];
  logic [OW-1:0]               qq_w    [0:NCELL];

  // Square root chain links.
  logic                        sv_w    [0:NCELL];
  logic                        sr_w    [0:NCELL];
  logic signed [CW-1:0]        scos_w  [0:NCELL];
  fsr_pkg::fsr_flags_t         sflag_w [0:NCELL];
  logic [XW-1:0]               rem_w   [0:NCELL];
  logic [OW-1:0]               root_w  [0:NCELL];
  logic [OW-1:0]               q_w     [0:NCELL];

  logic [fsr_pkg::IN_W-1:0] d_front;
  logic [OW-1:0]            sin2;

  fsr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_eye_x    (in_eye_x),
    .in_eye_y    (in_eye_y),
    .in_eye_z    (in_eye_z),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .in_n1_index (in_n1_index),
    .in_n2_index (in_n2_index),
    .dn_valid    (dv_w[0]),
    .dn_ready    (dr_w[0]),
    .cos_o       (dcos_w[0]),
    .lhs_o       (lrem_w[0]),
    .n2sq_o      (n2sq_w[0]),
    .d_o         (d_front),
    .s_o         (s_w[0]),
    .flags_o     (dflag_w[0])
  );

  // Dividend of the q divider and empty quotients enter the first cell.
  assign qrem_w[0] = QW'(d_front) << FRAC_BITS;
  assign sq_w[0]   = '0;
  assign qq_w[0]   = '0;

  for (genvar j = 0; j < NCELL; j++) begin : g_div
    fsr_div_cell #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (FRAC_BITS - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_w[j]),
      .up_ready (dr_w[j]),
      .cos_i    (dcos_w[j]),
      .flags_i  (dflag_w[j]),
      .lrem_i   (lrem_w[j]),
      .n2sq_i   (n2sq_w[j]),
      .sq_i     (sq_w[j]),
      .qrem_i   (qrem_w[j]),
      .s_i      (s_w[j]),
      .qq_i     (qq_w[j]),
      .dn_valid (dv_w[j+1]),
      .dn_ready (dr_w[j+1]),
      .cos_o    (dcos_w[j+1]),
      .flags_o  (dflag_w[j+1]),
      .lrem_o   (lrem_w[j+1]),
      .n2sq_o   (n2sq_w[j+1]),
      .sq_o     (sq_w[j+1]),
      .qrem_o   (qrem_w[j+1]),
      .s_o      (s_w[j+1]),
      .qq_o     (qq_w[j+1])
    );
  end

  // Hand-off to the root chain: radicand (1 - sin2_t) << F when refracting without total reflection.
  assign sin2          = dflag_w[NCELL].lhs_zero ? '0 : sq_w[NCELL];
  assign sv_w[0]       = dv_w[NCELL];
  assign dr_w[NCELL]   = sr_w[0];
  assign scos_w[0]     = dcos_w[NCELL];
  assign sflag_w[0]    = dflag_w[NCELL];
  assign q_w[0]        = dflag_w[NCELL].s_zero ? '0 : qq_w[NCELL];
  assign root_w[0]     = '0;
  assign rem_w[0]      = (dflag_w[NCELL].refr && !dflag_w[NCELL].tir)
                         ? (XW'(ONE_U - sin2) << FRAC_BITS) : '0;

  for (genvar j = 0; j < NCELL; j++) begin : g_sqrt
    fsr_sqrt_cell #(
      .FRAC_BITS (FRAC_BITS),
      .STEP      (FRAC_BITS - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sv_w[j]),
      .up_ready (sr_w[j]),
      .cos_i    (scos_w[j]),
      .flags_i  (sflag_w[j]),
      .rem_i    (rem_w[j]),
      .root_i   (root_w[j]),
      .q_i      (q_w[j]),
      .dn_valid (sv_w[j+1]),
      .dn_ready (sr_w[j+1]),
      .cos_o    (scos_w[j+1]),
      .flags_o  (sflag_w[j+1]),
      .rem_o    (rem_w[j+1]),
      .root_o   (root_w[j+1]),
      .q_o      (q_w[j+1])
    );
  end

  fsr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .up_valid             (sv_w[NCELL]),
    .up_ready             (sr_w[NCELL]),
    .cos_i                (scos_w[NCELL]),
    .root_i               (root_w[NCELL]),
    .q_i                  (q_w[NCELL]),
    .flags_i              (sflag_w[NCELL]),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_reflectance      (out_reflectance),
    .out_total_reflection (out_total_reflection)
  );

  // With the sink taking beats every stage moves, so the input is open.
  `FSR_ASSERT_NEVER(a_ready_ripple, out_ready && !in_ready)
  // The input only closes when a result is waiting at the output.
  `FSR_ASSERT_IMPLY(a_stall_has_cause, !in_ready, out_valid && !out_ready)
  // Total reflection is only flagged when refracting (n1 > n2).
  `FSR_ASSERT_IMPLY(a_tir_needs_refr, dv_w[0] && dflag_w[0].tir, dflag_w[0].refr)

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Randomized check of the Fresnel reflectance pipeline. Hits are driven with
// random idling on both sides; a scoreboard predicts each reflectance beat
// and compares it in order with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the predicted reflectance beats in arrival order.
class reflectance_scoreboard;
  typedef struct {
    logic [14:0] refl;
    logic        tir;
  } refl_beat_t;

  refl_beat_t pending[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // Schlick reflectance for one hit, all shifts at 14 fraction bits.
  function refl_beat_t predict_reflectance(
    logic signed [15:0] ex, logic signed [15:0] ey, logic signed [15:0] ez,
    logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
    logic [15:0] n1i, logic [15:0] n2i);
    longint     one;
    longint     dot;
    longint     cosv;
    longint     c2, omc2, lhs, n2sq, sin2, d, s, q, r0, b, b2, b4, b5, refl;
    longint     rad, root, bitv;
    logic       tir;
    refl_beat_t res;
    one = 64'sd16384;
    dot = longint'(ex) * nx + longint'(ey) * ny + longint'(ez) * nz;
    cosv = dot >>> 14;
    tir = 1'b0;
    if (cosv > one) cosv = one;
    if (cosv < -one) cosv = -one;
    if (n1i > n2i) begin
      c2 = (cosv * cosv) >>> 14;
      omc2 = one - c2;
      lhs = longint'(n1i) * n1i * omc2;
      n2sq = longint'(n2i) * n2i;
      if (lhs > n2sq * one) begin
        tir = 1'b1;
      end else begin
        sin2 = (lhs == 0) ? 0 : lhs / n2sq;
        if (sin2 > one) sin2 = one;
        // Integer square root, rounded down.
        rad = (one - sin2) << 14;
        root = 0;
        bitv = 64'sd1 << 30;
        while (bitv > rad) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (rad >= root + bitv) begin
            rad = rad - (root + bitv);
            root = (root >> 1) + bitv;
          end else begin
            root = root >> 1;
          end
          bitv = bitv >> 2;
        end
        cosv = root;
        if (cosv > one) cosv = one;
      end
    end
    if (tir || cosv <= 0) begin
      refl = one;
    end else begin
      d = (n1i > n2i) ? n1i - n2i : n2i - n1i;
      s = longint'(n1i) + n2i;
      q = (s == 0) ? 0 : (d << 14) / s;
      if (q > one) q = one;
      r0 = (q * q) >> 14;
      b = one - cosv;
      b2 = (b * b) >> 14;
      b4 = (b2 * b2) >> 14;
      b5 = (b4 * b) >> 14;
      refl = r0 + (((one - r0) * b5) >> 14);
      if (refl > one) refl = one;
    end
    res.refl = refl[14:0];
    res.tir = tir;
    return res;
  endfunction

  function void note_hit(
    logic signed [15:0] ex, logic signed [15:0] ey, logic signed [15:0] ez,
    logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
    logic [15:0] n1i, logic [15:0] n2i);
    pending.insert(pending.size(),
                   predict_reflectance(ex, ey, ez, nx, ny, nz, n1i, n2i));
  endfunction

  function void check_beat(logic [14:0] refl, logic tir);
    refl_beat_t exp_beat;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat refl=%0d tir=%0b", $realtime, refl, tir);
      errors++;
      return;
    end
    exp_beat = pending.pop_front();
    if (refl !== exp_beat.refl) begin
      $display("%0t: reflectance expected %0d actual %0d", $realtime,
               exp_beat.refl, refl);
      errors++;
    end
    if (tir !== exp_beat.tir) begin
      $display("%0t: total_reflection expected %0b actual %0b", $realtime,
               exp_beat.tir, tir);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int LATENCY   = 41;
  localparam int WDOG_MAX  = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_eye_x, in_eye_y, in_eye_z;
  logic signed [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic        [15:0] in_n1_index, in_n2_index;
  logic               out_valid;
  logic               out_ready;
  logic        [14:0] out_reflectance;
  logic               out_total_reflection;

  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;
  reflectance_scoreboard sb;

  fresnel_schlick_reflectance_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_eye_x            (in_eye_x),
    .in_eye_y            (in_eye_y),
    .in_eye_z            (in_eye_z),
    .in_normal_x         (in_normal_x),
    .in_normal_y         (in_normal_y),
    .in_normal_z         (in_normal_z),
    .in_n1_index         (in_n1_index),
    .in_n2_index         (in_n2_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_reflectance     (out_reflectance),
    .out_total_reflection(out_total_reflection)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result beat and count cycles that move nothing.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_beat(out_reflectance, out_total_reflection);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver stalls at random, changing at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Present one hit, wait for acceptance, then note it. Valid drops only
  // in the idle cycles before a hit or in wait_drained.
  task automatic send_hit(input logic signed [15:0] ex, ey, ez, nx, ny, nz,
                          input logic [15:0] n1i, n2i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_eye_x <= ex; in_eye_y <= ey; in_eye_z <= ez;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_n1_index <= n1i; in_n2_index <= n2i;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_hit(ex, ey, ez, nx, ny, nz, n1i, n2i);
    @(negedge clk);
  endtask

  // Random unit-ish vector component, biased toward valid range.
  function automatic logic signed [15:0] rand_comp();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return (sel[0] ? 16'sd16384 : -16'sd16384);
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [15:0] rand_index();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(65535, 16384));
  endfunction

  // Random hit: mostly a normalized pair, sometimes raw noise.
  task automatic send_random_hit();
    real vx, vy, vz, len, wx, wy, wz, wl;
    logic [15:0] n1i, n2i;
    n1i = rand_index();
    n2i = rand_index();
    if ($urandom_range(9) < 7) begin
      vx = $itor($signed($urandom_range(2000)) - 1000);
      vy = $itor($signed($urandom_range(2000)) - 1000);
      vz = $itor($signed($urandom_range(2000)) - 999);
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      wx = $itor($signed($urandom_range(2000)) - 1000);
      wy = $itor($signed($urandom_range(2000)) - 1000);
      wz = $itor($signed($urandom_range(2000)) - 999);
      wl = $sqrt(wx * wx + wy * wy + wz * wz);
      send_hit(16'($rtoi(vx / len * 16384.0)), 16'($rtoi(vy / len * 16384.0)),
               16'($rtoi(vz / len * 16384.0)), 16'($rtoi(wx / wl * 16384.0)),
               16'($rtoi(wy / wl * 16384.0)), 16'($rtoi(wz / wl * 16384.0)),
               n1i, n2i);
    end else begin
      send_hit(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
               rand_comp(), n1i, n2i);
    end
  endtask

  // Drop valid and wait until every predicted beat has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_eye_x = '0; in_eye_y = '0; in_eye_z = '0;
    in_normal_x = '0; in_normal_y = '0; in_normal_z = '0;
    in_n1_index = '0; in_n2_index = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed hits: head-on, grazing, backfacing, over-range dot,
    // total reflection, zero indexes, all-ones fields.
    send_hit(16384, 0, 0, 16384, 0, 0, 16384, 24576);
    send_hit(16384, 0, 0, 16384, 0, 0, 24576, 16384);
    send_hit(16384, 0, 0, 0, 16384, 0, 16384, 24576);
    send_hit(16384, 0, 0, -16384, 0, 0, 16384, 24576);
    send_hit(-16384, -16384, -16384, -16384, -16384, -16384, 16384, 24576);
    send_hit(16384, 16384, 16384, -16384, -16384, -16384, 16384, 16384);
    send_hit(11585, 11585, 0, 16384, 0, 0, 24576, 16384);
    send_hit(11585, 11585, 0, 16384, 0, 0, 65535, 16384);
    send_hit(14189, 8192, 0, 16384, 0, 0, 21299, 16384);
    send_hit(16384, 0, 0, 16384, 0, 0, 16384, 0);
    send_hit(11585, 11585, 0, 16384, 0, 0, 16384, 0);
    send_hit(16384, 0, 0, 16384, 0, 0, 0, 0);
    send_hit(0, 0, 0, 0, 0, 0, 0, 0);
    send_hit(-1, -1, -1, -1, -1, -1, 65535, 65535);
    send_hit(-32768, 32767, -32768, 32767, -32768, 32767, 65535, 1);
    send_hit(32767, 32767, 32767, 32767, 32767, 32767, 1, 65535);
    send_hit(16384, 0, 0, 16383, 0, 0, 16384, 16384);
    send_hit(0, 0, 16384, 0, 0, 16384, 26214, 16384);

    // Let the pipeline empty before random traffic.
    wait_drained();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int i = 0; i < 410; i++) send_random_hit();
    end

    wait_drained();
    recv_stall_pct = 0;
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/fsr_pkg.sv
rtl/core/fsr_front.sv
rtl/core/fsr_div_cell.sv
rtl/core/fsr_sqrt_cell.sv
rtl/core/fsr_back.sv
rtl/core/fresnel_schlick_reflectance_top.sv
bench/tb_top.sv
